// File: design/linear_probe_hash_set_macros.svh
// ----------------------------------------------------------------------------
// Linear probe hash set assertion macros
// Shared forms for the concurrent checks on the hash set ports.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LPHS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hash set check failed");

// Next-cycle implication, disabled while reset is high.
`define LPHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hash set check failed");

`endif

// File: design/lphs_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash set package
// Table geometry, field widths and the operation and slot mark codes.
// ----------------------------------------------------------------------------
package lphs_pkg;

   localparam int TABLE_SLOTS = 1024;
   localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
   localparam int KEY_BITS    = 32;
   localparam int MARK_BITS   = 2;
   localparam int WORD_BITS   = MARK_BITS + KEY_BITS;
   localparam int COUNT_BITS  = 11;
   localparam int OP_BITS     = 2;

   localparam logic [COUNT_BITS-1:0] MAX_ENTRIES_RESET = COUNT_BITS'(512);
   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT       = COUNT_BITS'(TABLE_SLOTS);

   typedef enum logic [OP_BITS-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [MARK_BITS-1:0] {
      MARK_EMPTY = 2'd0,
      MARK_LIVE  = 2'd1,
      MARK_TOMB  = 2'd2,
      MARK_SPARE = 2'd3
   } mark_type;

endpackage

// File: design/linear_probe_hash_set.sv
// ----------------------------------------------------------------------------
// Linear probe hash set
// Open-addressing set of 32-bit keys with linear probing and tombstones,
// held in one synchronous slot memory of marks and keys.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              word
//   req      in         req_valid/req_ready    req_opcode, req_key
//   rsp      out        rsp_valid/rsp_ready    rsp_success, rsp_refused_full,
//                                              rsp_live_count
//   csr      in         csr_valid/csr_ready    csr_max_entries
//
// An operation probes P slots one after another (P from 1 to 1024), since
// the slot memory returns one read per cycle.
// After reset a clearing pass marks all 1024 slots empty;
// req_ready stays low during it while csr writes are taken as usual.
// A result waiting in the output register stalls only the final probe step.
// ----------------------------------------------------------------------------
module linear_probe_hash_set (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [lphs_pkg::OP_BITS-1:0]       req_opcode,
   input  logic signed [lphs_pkg::KEY_BITS-1:0] req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_success,
   output logic                               rsp_refused_full,
   output logic [lphs_pkg::COUNT_BITS-1:0]    rsp_live_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lphs_pkg::COUNT_BITS-1:0]    csr_max_entries
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_PROBE = 3'b100
   } state_type;

   localparam logic [lphs_pkg::SLOT_BITS-1:0] LAST_SLOT =
      lphs_pkg::SLOT_BITS'(lphs_pkg::TABLE_SLOTS - 1);

   state_type                            state_ff, state_in;
   logic [lphs_pkg::SLOT_BITS-1:0]       clr_idx_ff, clr_idx_in;
   logic [lphs_pkg::SLOT_BITS-1:0]       probe_idx_ff, probe_idx_in;
   logic [lphs_pkg::SLOT_BITS-1:0]       probe_n_ff, probe_n_in;
   logic                                 free_vld_ff, free_vld_in;
   logic [lphs_pkg::SLOT_BITS-1:0]       free_idx_ff, free_idx_in;
   lphs_pkg::op_type                     op_ff, op_in;
   logic [lphs_pkg::KEY_BITS-1:0]        key_ff, key_in;
   logic [lphs_pkg::COUNT_BITS-1:0]      count_ff, count_in;
   logic [lphs_pkg::COUNT_BITS-1:0]      max_ff, max_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_success_ff, rsp_success_in;
   logic                                 rsp_refused_ff, rsp_refused_in;
   logic [lphs_pkg::COUNT_BITS-1:0]      rsp_count_ff, rsp_count_in;

   logic [lphs_pkg::WORD_BITS-1:0]       slot_mem [lphs_pkg::TABLE_SLOTS];
   logic [lphs_pkg::WORD_BITS-1:0]       rd_data_ff;
   logic [lphs_pkg::SLOT_BITS-1:0]       rd_addr;
   logic                                 wr_en;
   logic [lphs_pkg::SLOT_BITS-1:0]       wr_addr;
   logic [lphs_pkg::WORD_BITS-1:0]       wr_data;

   lphs_pkg::mark_type                   slot_mark;
   logic [lphs_pkg::KEY_BITS-1:0]        slot_key;
   logic                                 slot_live;
   logic                                 slot_hit;
   logic                                 probe_done;
   logic                                 out_free;
   logic                                 cand_vld;
   logic [lphs_pkg::SLOT_BITS-1:0]       cand_idx;
   logic                                 over_limit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign slot_mark  = lphs_pkg::mark_type'(rd_data_ff[lphs_pkg::WORD_BITS-1:lphs_pkg::KEY_BITS]);
   assign slot_key   = rd_data_ff[lphs_pkg::KEY_BITS-1:0];
   assign slot_live  = (slot_mark == lphs_pkg::MARK_LIVE);
   assign slot_hit   = slot_live && (slot_key == key_ff);
   assign probe_done = (op_ff == lphs_pkg::OP_NONE) || slot_hit ||
                       (slot_mark == lphs_pkg::MARK_EMPTY) || (probe_n_ff == LAST_SLOT);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cand_vld   = free_vld_ff || !slot_live;
   assign cand_idx   = free_vld_ff ? free_idx_ff : probe_idx_ff;
   assign over_limit = ({1'b0, count_ff} + 1'b1) > {1'b0, max_ff};

   always_comb begin
      state_in       = state_ff;
      clr_idx_in     = clr_idx_ff;
      probe_idx_in   = probe_idx_ff;
      probe_n_in     = probe_n_ff;
      free_vld_in    = free_vld_ff;
      free_idx_in    = free_idx_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      count_in       = count_ff;
      max_in         = csr_valid ? csr_max_entries : max_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_success_in = rsp_success_ff;
      rsp_refused_in = rsp_refused_ff;
      rsp_count_in   = rsp_count_ff;
      rd_addr        = probe_idx_ff;
      wr_en          = 1'b0;
      wr_addr        = probe_idx_ff;
      wr_data        = rd_data_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = {lphs_pkg::MARK_EMPTY, {lphs_pkg::KEY_BITS{1'b0}}};
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = req_key[lphs_pkg::SLOT_BITS-1:0];
            if (req_valid) begin
               op_in        = lphs_pkg::op_type'(req_opcode);
               key_in       = req_key;
               probe_idx_in = req_key[lphs_pkg::SLOT_BITS-1:0];
               probe_n_in   = '0;
               free_vld_in  = 1'b0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (!probe_done) begin
               probe_idx_in = probe_idx_ff + 1'b1;
               probe_n_in   = probe_n_ff + 1'b1;
               rd_addr      = probe_idx_ff + 1'b1;
               if (!free_vld_ff && !slot_live) begin
                  free_vld_in = 1'b1;
                  free_idx_in = probe_idx_ff;
               end
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = 1'b0;
               rsp_refused_in = 1'b0;
               state_in       = ST_IDLE;
               case (op_ff)
                  lphs_pkg::OP_LOOKUP: begin
                     rsp_success_in = slot_hit;
                  end
                  lphs_pkg::OP_INSERT: begin
                     if (!slot_hit) begin
                        if (over_limit || !cand_vld) begin
                           rsp_refused_in = 1'b1;
                        end else begin
                           wr_en          = 1'b1;
                           wr_addr        = cand_idx;
                           wr_data        = {lphs_pkg::MARK_LIVE, key_ff};
                           count_in       = count_ff + 1'b1;
                           rsp_success_in = 1'b1;
                        end
                     end
                  end
                  lphs_pkg::OP_REMOVE: begin
                     if (slot_hit) begin
                        wr_en          = 1'b1;
                        wr_data        = {lphs_pkg::MARK_TOMB, slot_key};
                        rsp_success_in = 1'b1;
                        if (count_ff != '0) begin
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         count_ff     <= '0;
         max_ff       <= lphs_pkg::MAX_ENTRIES_RESET;
         rsp_valid_ff <= 1'b0;
         free_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         count_ff     <= count_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         free_vld_ff  <= free_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_idx_ff   <= probe_idx_in;
      probe_n_ff     <= probe_n_in;
      free_idx_ff    <= free_idx_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      rsp_success_ff <= rsp_success_in;
      rsp_refused_ff <= rsp_refused_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_refused_full = rsp_refused_ff;
   assign rsp_live_count   = rsp_count_ff;

endmodule

// File: design/lphs_checker.sv
// ----------------------------------------------------------------------------
// Linear probe hash set checker
// Port-level checks on the hash set, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_set_macros.svh"

module lphs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_success,
   input logic                            rsp_refused_full,
   input logic [lphs_pkg::COUNT_BITS-1:0] rsp_live_count
);

   // A result never claims both success and a refusal.
   `LPHS_ASSERT_NOW(a_outcome_exclusive, clock, reset, rsp_valid, !(rsp_success && rsp_refused_full))

   // The live count never exceeds the table capacity.
   `LPHS_ASSERT_NOW(a_count_bounded, clock, reset, rsp_valid, rsp_live_count <= lphs_pkg::COUNT_LIMIT)

   // The table is being cleared in the first cycle after reset.
   `LPHS_ASSERT_NOW(a_clear_after_reset, clock, reset, $past(reset), !req_ready)

   // The block works on one request at a time.
   `LPHS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_success      (rsp_success),
   .rsp_refused_full (rsp_refused_full),
   .rsp_live_count   (rsp_live_count)
);
